// File: hw/rtl/nvfs_pkg.sv
// Package: shared constants, format table and stage control type for the format selector
`timescale 1ns / 1ps

package nvfs_pkg;

  localparam int FMT_BITS      = 4;
  localparam int SCORE_BITS    = 30;
  localparam int POS_OUT_BITS  = 8;
  localparam int BPP_BITS      = 6;
  localparam int PLANE_BITS    = 2;
  localparam int ADDR_BITS     = 4;
  localparam int DATA_BITS     = 32;

  localparam logic [FMT_BITS-1:0]   NUM_FORMATS = 4'd12;
  localparam logic [SCORE_BITS-1:0] SCORE_MAX   = '1;

  // Pixel format indexes in table order
  localparam logic [FMT_BITS-1:0] FMT_RGB32 = 4'd0;
  localparam logic [FMT_BITS-1:0] FMT_RGB24 = 4'd1;
  localparam logic [FMT_BITS-1:0] FMT_RGB16 = 4'd2;
  localparam logic [FMT_BITS-1:0] FMT_RGB15 = 4'd3;
  localparam logic [FMT_BITS-1:0] FMT_BGR32 = 4'd4;
  localparam logic [FMT_BITS-1:0] FMT_BGR24 = 4'd5;
  localparam logic [FMT_BITS-1:0] FMT_BGR16 = 4'd6;
  localparam logic [FMT_BITS-1:0] FMT_BGR15 = 4'd7;
  localparam logic [FMT_BITS-1:0] FMT_UYVY  = 4'd8;
  localparam logic [FMT_BITS-1:0] FMT_YUY2  = 4'd9;
  localparam logic [FMT_BITS-1:0] FMT_NV12  = 4'd10;
  localparam logic [FMT_BITS-1:0] FMT_NV21  = 4'd11;

  // Register indexes on the configuration port (word address)
  typedef enum logic [1:0] {
    REG_TARGET_FORMAT = 2'd0,
    REG_TARGET_WIDTH  = 2'd1,
    REG_TARGET_HEIGHT = 2'd2
  } reg_index_t;

  // Control bits that travel with a candidate down the pipeline
  typedef struct packed {
    logic valid;    // stage holds a candidate
    logic last;     // candidate closes its list
    logic counted;  // candidate takes part in the comparison
  } stage_ctl_t;

  // Bits per pixel of each known format; unknown formats give 0
  function automatic logic [BPP_BITS-1:0] fmt_bpp(input logic [FMT_BITS-1:0] fmt);
    logic [BPP_BITS-1:0] bpp;
    case (fmt)
      FMT_RGB32, FMT_BGR32:            bpp = 6'd32;
      FMT_RGB24, FMT_BGR24:            bpp = 6'd24;
      FMT_RGB16, FMT_RGB15, FMT_BGR16,
      FMT_BGR15, FMT_UYVY, FMT_YUY2:   bpp = 6'd16;
      FMT_NV12, FMT_NV21:              bpp = 6'd12;
      default:                         bpp = 6'd0;
    endcase
    return bpp;
  endfunction

  // Plane count of each known format; unknown formats give 0
  function automatic logic [PLANE_BITS-1:0] fmt_planes(input logic [FMT_BITS-1:0] fmt);
    logic [PLANE_BITS-1:0] planes;
    case (fmt)
      FMT_NV12, FMT_NV21: planes = 2'd2;
      default:            planes = (fmt < NUM_FORMATS) ? 2'd1 : 2'd0;
    endcase
    return planes;
  endfunction

endpackage

// File: hw/rtl/nvfs_cfg_regs.sv
// Target format registers behind the APB-style configuration port
`timescale 1ns / 1ps

module nvfs_cfg_regs
  import nvfs_pkg::*;
#(
  parameter int DIM_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output logic [FMT_BITS-1:0]  target_format,
  output logic [DIM_BITS-1:0]  target_width,
  output logic [DIM_BITS-1:0]  target_height
);

  logic       wr_en;
  reg_index_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_index_t'(paddr[3:2]);

  // Write the addressed register on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      target_format <= '0;
      target_width  <= '0;
      target_height <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_TARGET_FORMAT: target_format <= pwdata[FMT_BITS-1:0];
        REG_TARGET_WIDTH:  target_width  <= pwdata[DIM_BITS-1:0];
        REG_TARGET_HEIGHT: target_height <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero-extended
  always_comb begin
    case (reg_sel)
      REG_TARGET_FORMAT: prdata = DATA_BITS'(target_format);
      REG_TARGET_WIDTH:  prdata = DATA_BITS'(target_width);
      REG_TARGET_HEIGHT: prdata = DATA_BITS'(target_height);
      default:           prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/nvfs_score.sv
// Input register, position counter and registered distance score of each candidate
`timescale 1ns / 1ps

module nvfs_score
  import nvfs_pkg::*;
#(
  parameter int MAX_CANDIDATES = 256,
  parameter int DIM_BITS       = 14
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 advance,
  input  logic                                 cand_valid,
  input  logic [FMT_BITS-1:0]                  cand_format,
  input  logic [DIM_BITS-1:0]                  cand_width,
  input  logic [DIM_BITS-1:0]                  cand_height,
  input  logic                                 is_last,
  input  logic [FMT_BITS-1:0]                  target_format,
  input  logic [DIM_BITS-1:0]                  target_width,
  input  logic [DIM_BITS-1:0]                  target_height,
  output stage_ctl_t                           b_ctl,
  output logic [SCORE_BITS-1:0]                b_score,
  output logic [FMT_BITS-1:0]                  b_format,
  output logic [DIM_BITS-1:0]                  b_width,
  output logic [DIM_BITS-1:0]                  b_height,
  output logic [$clog2(MAX_CANDIDATES)-1:0]    b_pos
);

  localparam int POS_BITS = $clog2(MAX_CANDIDATES);
  localparam int CNT_BITS = $clog2(MAX_CANDIDATES + 1);
  localparam int SQ_BITS  = 2 * DIM_BITS;
  localparam int SUM_BITS = (SQ_BITS + 2 > SCORE_BITS) ? SQ_BITS + 2 : SCORE_BITS + 1;
  localparam logic [CNT_BITS-1:0] CNT_LIMIT = CNT_BITS'(MAX_CANDIDATES);

  logic                  in_fire;
  logic [CNT_BITS-1:0]   seen_count;

  stage_ctl_t            a_ctl;
  logic [FMT_BITS-1:0]   a_format;
  logic [DIM_BITS-1:0]   a_width;
  logic [DIM_BITS-1:0]   a_height;
  logic [POS_BITS-1:0]   a_pos;

  logic [DIM_BITS-1:0]   diff_w;
  logic [DIM_BITS-1:0]   diff_h;
  logic [BPP_BITS-1:0]   cand_bpp;
  logic [BPP_BITS-1:0]   tgt_bpp;
  logic [BPP_BITS-1:0]   diff_bpp;
  logic [PLANE_BITS-1:0] cand_pl;
  logic [PLANE_BITS-1:0] tgt_pl;
  logic [PLANE_BITS-1:0] diff_pl;
  logic [SQ_BITS-1:0]    sq_w;
  logic [SQ_BITS-1:0]    sq_h;
  logic [2*BPP_BITS-1:0] sq_bpp;
  logic [2*PLANE_BITS-1:0] sq_pl;
  logic [SUM_BITS-1:0]   sum;
  logic [SCORE_BITS-1:0] score;

  assign in_fire = cand_valid & advance;

  // Count positions within a list; stop at the limit, restart after the last candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= '0;
    end else if (in_fire) begin
      if (is_last) begin
        seen_count <= '0;
      end else if (seen_count != CNT_LIMIT) begin
        seen_count <= seen_count + CNT_BITS'(1);
      end
    end
  end

  // Capture the request in the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
    end else if (advance) begin
      a_ctl.valid   <= cand_valid;
      a_ctl.last    <= is_last;
      a_ctl.counted <= (seen_count != CNT_LIMIT) && (cand_format < NUM_FORMATS);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_format <= cand_format;
      a_width  <= cand_width;
      a_height <= cand_height;
      a_pos    <= seen_count[POS_BITS-1:0];
    end
  end

  // Form the score: format mismatch plus four squared differences, saturated
  always_comb begin
    diff_w   = (a_width >= target_width) ? a_width - target_width : target_width - a_width;
    diff_h   = (a_height >= target_height) ? a_height - target_height
                                           : target_height - a_height;
    cand_bpp = fmt_bpp(a_format);
    tgt_bpp  = fmt_bpp(target_format);
    cand_pl  = fmt_planes(a_format);
    tgt_pl   = fmt_planes(target_format);
    diff_bpp = (cand_bpp >= tgt_bpp) ? cand_bpp - tgt_bpp : tgt_bpp - cand_bpp;
    diff_pl  = (cand_pl >= tgt_pl) ? cand_pl - tgt_pl : tgt_pl - cand_pl;
    sq_w     = SQ_BITS'(diff_w) * SQ_BITS'(diff_w);
    sq_h     = SQ_BITS'(diff_h) * SQ_BITS'(diff_h);
    sq_bpp   = (2*BPP_BITS)'(diff_bpp) * (2*BPP_BITS)'(diff_bpp);
    sq_pl    = (2*PLANE_BITS)'(diff_pl) * (2*PLANE_BITS)'(diff_pl);
    sum      = SUM_BITS'(sq_w) + SUM_BITS'(sq_h) + SUM_BITS'(sq_bpp) + SUM_BITS'(sq_pl)
             + SUM_BITS'(a_format != target_format);
    if (sum > SUM_BITS'(SCORE_MAX)) begin
      score = SCORE_MAX;
    end else begin
      score = sum[SCORE_BITS-1:0];
    end
  end

  // Advance the candidate and its score to the keep stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctl <= '0;
    end else if (advance) begin
      b_ctl <= a_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && a_ctl.valid) begin
      b_score  <= score;
      b_format <= a_format;
      b_width  <= a_width;
      b_height <= a_height;
      b_pos    <= a_pos;
    end
  end

endmodule

// File: hw/rtl/nvfs_keep.sv
// Running best candidate of the current list and the result register
`timescale 1ns / 1ps

module nvfs_keep
  import nvfs_pkg::*;
#(
  parameter int MAX_CANDIDATES = 256,
  parameter int DIM_BITS       = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  stage_ctl_t                        b_ctl,
  input  logic [SCORE_BITS-1:0]             b_score,
  input  logic [FMT_BITS-1:0]               b_format,
  input  logic [DIM_BITS-1:0]               b_width,
  input  logic [DIM_BITS-1:0]               b_height,
  input  logic [$clog2(MAX_CANDIDATES)-1:0] b_pos,
  output logic                              advance,
  output logic                              best_valid,
  input  logic                              best_stall,
  output logic [POS_OUT_BITS-1:0]           best_position,
  output logic [FMT_BITS-1:0]               best_format,
  output logic [DIM_BITS-1:0]               best_width,
  output logic [DIM_BITS-1:0]               best_height,
  output logic [SCORE_BITS-1:0]             best_score
);

  localparam int POS_BITS = $clog2(MAX_CANDIDATES);

  logic                  out_free;
  logic                  b_fire;
  logic                  take;

  logic                  low_valid;
  logic [SCORE_BITS-1:0] low_score;
  logic [FMT_BITS-1:0]   low_format;
  logic [DIM_BITS-1:0]   low_width;
  logic [DIM_BITS-1:0]   low_height;
  logic [POS_BITS-1:0]   low_position;

  logic [SCORE_BITS-1:0] low_score_next;
  logic [FMT_BITS-1:0]   low_format_next;
  logic [DIM_BITS-1:0]   low_width_next;
  logic [DIM_BITS-1:0]   low_height_next;
  logic [POS_BITS-1:0]   low_position_next;
  logic [POS_BITS+POS_OUT_BITS-1:0] pos_ext;

  // Hold the pipeline only when a closing candidate meets a result still waiting
  assign out_free = ~best_valid | ~best_stall;
  assign b_fire   = b_ctl.valid & (~b_ctl.last | out_free);
  assign advance  = ~b_ctl.valid | b_fire;

  // Keep the candidate if it is the first counted one or strictly better
  assign take = b_ctl.counted & (~low_valid | (b_score < low_score));

  always_comb begin
    if (take) begin
      low_score_next    = b_score;
      low_format_next   = b_format;
      low_width_next    = b_width;
      low_height_next   = b_height;
      low_position_next = b_pos;
    end else begin
      low_score_next    = low_score;
      low_format_next   = low_format;
      low_width_next    = low_width;
      low_height_next   = low_height;
      low_position_next = low_position;
    end
  end

  // Update the running best; clear it once the list closes
  always_ff @(posedge clk) begin
    if (rst) begin
      low_valid    <= 1'b0;
      low_score    <= SCORE_MAX;
      low_format   <= '0;
      low_width    <= '0;
      low_height   <= '0;
      low_position <= '0;
    end else if (b_fire) begin
      if (b_ctl.last) begin
        low_valid    <= 1'b0;
        low_score    <= SCORE_MAX;
        low_format   <= '0;
        low_width    <= '0;
        low_height   <= '0;
        low_position <= '0;
      end else begin
        low_valid    <= low_valid | take;
        low_score    <= low_score_next;
        low_format   <= low_format_next;
        low_width    <= low_width_next;
        low_height   <= low_height_next;
        low_position <= low_position_next;
      end
    end
  end

  assign pos_ext = {{POS_OUT_BITS{1'b0}}, low_position_next};

  // Load the result register on a closing candidate; drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
    end else if (b_fire && b_ctl.last) begin
      best_valid <= 1'b1;
    end else if (!best_stall) begin
      best_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_ctl.last) begin
      best_position <= pos_ext[POS_OUT_BITS-1:0];
      best_format   <= low_format_next;
      best_width    <= low_width_next;
      best_height   <= low_height_next;
      best_score    <= low_score_next;
    end
  end

  // A waiting result is never overwritten by the next closing candidate
  assert property (@(posedge clk) disable iff (rst)
    best_valid && best_stall && b_ctl.valid && b_ctl.last |-> !advance)
    else $error("result register overwritten while stalled");

  // The running best is empty after every closing candidate
  assert property (@(posedge clk) disable iff (rst)
    b_fire && b_ctl.last |=> !low_valid)
    else $error("selection not cleared at end of list");

  // An empty selection carries the reset score
  assert property (@(posedge clk) disable iff (rst)
    !low_valid |-> low_score == SCORE_MAX)
    else $error("empty selection holds a score");

  // A list with nothing counted reports the reset values
  assert property (@(posedge clk) disable iff (rst)
    b_fire && b_ctl.last && !low_valid && !b_ctl.counted
      |=> best_score == SCORE_MAX && best_position == '0)
    else $error("empty list result wrong");

endmodule

// File: hw/rtl/nearest_video_format_select.sv
// Top level: picks the candidate video format nearest to the configured target
// A closing candidate passes through the input stage, the score stage and then
// compare-and-keep into the result register.
// Throughput: one candidate per cycle; input stalls only while a result waits and
// the next closing candidate has reached the keep stage.
// Reset clears the target registers, the position count and the running best.
`timescale 1ns / 1ps

module nearest_video_format_select
  import nvfs_pkg::*;
#(
  parameter int MAX_CANDIDATES = 256,
  parameter int DIM_BITS       = 14
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_BITS-1:0]    paddr,
  input  logic [DATA_BITS-1:0]    pwdata,
  output logic [DATA_BITS-1:0]    prdata,
  output logic                    pready,
  input  logic                    cand_valid,
  output logic                    cand_stall,
  input  logic [FMT_BITS-1:0]     cand_format,
  input  logic [DIM_BITS-1:0]     cand_width,
  input  logic [DIM_BITS-1:0]     cand_height,
  input  logic                    is_last,
  output logic                    best_valid,
  input  logic                    best_stall,
  output logic [POS_OUT_BITS-1:0] best_position,
  output logic [FMT_BITS-1:0]     best_format,
  output logic [DIM_BITS-1:0]     best_width,
  output logic [DIM_BITS-1:0]     best_height,
  output logic [SCORE_BITS-1:0]   best_score
);

  localparam int POS_BITS = $clog2(MAX_CANDIDATES);

  logic [FMT_BITS-1:0]   target_format;
  logic [DIM_BITS-1:0]   target_width;
  logic [DIM_BITS-1:0]   target_height;
  logic                  advance;
  stage_ctl_t            b_ctl;
  logic [SCORE_BITS-1:0] b_score;
  logic [FMT_BITS-1:0]   b_format;
  logic [DIM_BITS-1:0]   b_width;
  logic [DIM_BITS-1:0]   b_height;
  logic [POS_BITS-1:0]   b_pos;

  assign cand_stall = ~advance;

  // Hold the target format registers
  nvfs_cfg_regs #(
    .DIM_BITS(DIM_BITS)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .target_format (target_format),
    .target_width  (target_width),
    .target_height (target_height)
  );

  // Register each request and score it
  nvfs_score #(
    .MAX_CANDIDATES(MAX_CANDIDATES),
    .DIM_BITS      (DIM_BITS)
  ) u_score (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .cand_valid    (cand_valid),
    .cand_format   (cand_format),
    .cand_width    (cand_width),
    .cand_height   (cand_height),
    .is_last       (is_last),
    .target_format (target_format),
    .target_width  (target_width),
    .target_height (target_height),
    .b_ctl         (b_ctl),
    .b_score       (b_score),
    .b_format      (b_format),
    .b_width       (b_width),
    .b_height      (b_height),
    .b_pos         (b_pos)
  );

  // Keep the best candidate and present the result
  nvfs_keep #(
    .MAX_CANDIDATES(MAX_CANDIDATES),
    .DIM_BITS      (DIM_BITS)
  ) u_keep (
    .clk           (clk),
    .rst           (rst),
    .b_ctl         (b_ctl),
    .b_score       (b_score),
    .b_format      (b_format),
    .b_width       (b_width),
    .b_height      (b_height),
    .b_pos         (b_pos),
    .advance       (advance),
    .best_valid    (best_valid),
    .best_stall    (best_stall),
    .best_position (best_position),
    .best_format   (best_format),
    .best_width    (best_width),
    .best_height   (best_height),
    .best_score    (best_score)
  );

endmodule
